// File: hw/rtl/fir_filter_q15_saturating_core_macros.svh
// Assertion macros used by the checker file of the FIR core.
`ifndef FIR_FILTER_Q15_SATURATING_CORE_MACROS_SVH
`define FIR_FILTER_Q15_SATURATING_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fqs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fqs assertion failed");

`endif

// File: hw/rtl/fqs_pkg.sv
// Package of types, codes and constants for the Q15 FIR core.
`default_nettype none
package fqs_pkg;

    localparam int DEF_TAPS   = 32;
    localparam int COEF_SLOTS = 32;

    localparam int ACTION_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 31;
    localparam int SHIFT    = 15;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COEF   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_INIT = 31'sd16384;
    localparam logic signed [ACC_W-1:0] ACC_MAX  = 31'sh3fffffff;
    localparam logic signed [ACC_W-1:0] ACC_MIN  = 31'sh40000000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_PUSH
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/fqs_in_if.sv
// Input channel of the FIR core: action, sample and coefficient word.
`default_nettype none
interface fqs_in_if;
    logic                                valid;
    logic                                ready;
    logic        [fqs_pkg::ACTION_W-1:0] action;
    logic signed [fqs_pkg::SAMPLE_W-1:0] sample;
    logic        [fqs_pkg::CIDX_W-1:0]   coef_index;
    logic signed [fqs_pkg::COEF_W-1:0]   coef_value;

    modport source (output valid, output action, output sample, output coef_index,
                    output coef_value, input ready);
    modport sink   (input valid, input action, input sample, input coef_index,
                    input coef_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fqs_out_if.sv
// Output channel of the FIR core: one filtered sample per word.
`default_nettype none
interface fqs_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [fqs_pkg::OUT_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fir_filter_q15_saturating_core.sv
// Q15 direct-form FIR filter with one shared multiply-accumulate unit.
// Usage:
//   i_smp takes one word per valid/ready handshake. action selects:
//   filter a sample, write a coefficient (coef_index, coef_value), or
//   clear the sample history and write pointer (coefficients are kept).
//   o_res gives one filtered word for each sample word, none otherwise.
// Timing:
//   A sample word runs the shared MAC once per tap: after acceptance the
//   result becomes valid on o_res and i_smp is ready again at that same
//   edge, so no new word is taken while a sample runs. The wait is set
//   by the tap loop through the single history/coefficient read port pair
//   and multiplier, plus two pipeline stages (read, multiply) and one
//   output load. Coefficient and clear words leave the input ready.
// Reset:
//   History, coefficients and write pointer read as zero after reset;
//   valid bits and a fill count stand in for clearing the stores.
// Stall:
//   A result waits in the output register while o_res.ready is low; new
//   words are still accepted, and a finished sample holds in the load step
//   until the register frees.
`default_nettype none
module fir_filter_q15_saturating_core #(
    parameter int TAPS = fqs_pkg::DEF_TAPS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fqs_in_if.sink     i_smp,
    fqs_out_if.source  o_res
);
    import fqs_pkg::*;

    localparam int PW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW  = $clog2(TAPS + 1);
    localparam int CD  = (TAPS < COEF_SLOTS) ? TAPS : COEF_SLOTS;
    localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(TAPS - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(TAPS);

    // Stores.
    logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
    logic signed [COEF_W-1:0]   coef_mem [CD];
    logic        [CD-1:0]       r_cvld;

    // Control.
    t_state          r_state, n_state;
    logic [PW-1:0]   r_wp;
    logic [FW-1:0]   r_fill;
    logic [PW-1:0]   r_k;
    logic [PW-1:0]   r_pos;
    logic            r_rv, r_last_b;
    logic            r_pv, r_last_c;
    logic            r_out_valid;

    // Datapath.
    logic signed [SAMPLE_W-1:0] r_h;
    logic signed [COEF_W-1:0]   r_c;
    logic                       r_hv, r_cv;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [OUT_W-1:0]    r_out_data;

    logic                       in_ready, issue, push, out_free;
    logic                       in_acc, acc_sample, acc_coef, acc_clear, idx_ok;
    logic signed [SAMPLE_W-1:0] mul_h;
    logic signed [COEF_W-1:0]   mul_c;
    logic signed [ACC_W+1:0]    sum;
    logic signed [ACC_W-1:0]    sat;
    logic                       fill_full;

    assign out_free   = !r_out_valid || o_res.ready;
    assign in_acc     = i_smp.valid && in_ready;
    assign acc_sample = in_acc && (i_smp.action == ACT_SAMPLE);
    assign acc_coef   = in_acc && (i_smp.action == ACT_COEF);
    assign acc_clear  = in_acc && (i_smp.action == ACT_CLEAR);
    assign idx_ok     = 32'(i_smp.coef_index) < CD;
    assign fill_full  = (r_fill == FULL_CNT);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_sample) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_k == LAST_POS) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_pv && r_last_c) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        push     = 1'b0;
        case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_FLUSH: ;
            ST_PUSH:  push     = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_cvld      <= '0;
            r_rv        <= 1'b0;
            r_last_b    <= 1'b0;
            r_pv        <= 1'b0;
            r_last_c    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_sample) begin
                r_wp <= (r_wp == LAST_POS) ? '0 : r_wp + 1'b1;
                if (!fill_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (acc_clear) begin
                r_wp   <= '0;
                r_fill <= '0;
            end
            if (acc_coef && idx_ok) begin
                r_cvld[i_smp.coef_index[CAW-1:0]] <= 1'b1;
            end
            r_rv     <= issue;
            r_last_b <= issue && (r_k == LAST_POS);
            r_pv     <= r_rv;
            r_last_c <= r_last_b;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Store writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            hist_mem[r_wp] <= i_smp.sample;
        end
        if (acc_coef && idx_ok) begin
            coef_mem[i_smp.coef_index[CAW-1:0]] <= i_smp.coef_value;
        end
        r_h <= hist_mem[r_pos];
        r_c <= coef_mem[r_k[CAW-1:0]];
    end

    // Tap walk: newest sample first, pointer steps back with wrap.
    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_k   <= '0;
            r_pos <= r_wp;
        end else if (issue) begin
            r_k   <= r_k + 1'b1;
            r_pos <= (r_pos == '0) ? LAST_POS : r_pos - 1'b1;
        end
        // Entries never written since reset (history: since clear) read as zero.
        r_hv <= fill_full || (32'(r_pos) < 32'(r_fill));
        r_cv <= r_cvld[r_k[CAW-1:0]] && (32'(r_k) < CD);
    end

    assign mul_h = r_hv ? r_h : '0;
    assign mul_c = r_cv ? r_c : '0;

    assign sum = (ACC_W + 2)'(r_acc) + (ACC_W + 2)'(r_prod);

    always_comb begin
        if (sum > (ACC_W + 2)'(ACC_MAX)) begin
            sat = ACC_MAX;
        end else if (sum < (ACC_W + 2)'(ACC_MIN)) begin
            sat = ACC_MIN;
        end else begin
            sat = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_c) * PROD_W'(mul_h);
        if (acc_sample) begin
            r_acc <= ACC_INIT;
        end else if (r_pv) begin
            r_acc <= sat;
        end
        if (push) begin
            r_out_data <= r_acc[ACC_W-1:SHIFT];
        end
    end

    assign i_smp.ready    = in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.filtered = r_out_data;

endmodule
`default_nettype wire

// File: hw/rtl/fqs_checker.sv
// Port-level checker for the FIR core and its bind to the top level.
`default_nettype none
`include "fir_filter_q15_saturating_core_macros.svh"
module fqs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic [fqs_pkg::ACTION_W-1:0]  i_in_action,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [fqs_pkg::OUT_W-1:0]     i_out_filtered
);
    import fqs_pkg::*;

    logic in_acc;
    logic out_stall, smp_acc, other_acc;
    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign smp_acc   = in_acc && (i_in_action == ACT_SAMPLE);
    assign other_acc = in_acc && (i_in_action != ACT_SAMPLE);

    // A stalled result word holds.
    `FQS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_filtered))

    // A sample word keeps the input closed while the taps run.
    `FQS_ASSERT_NEXT(a_busy_after_sample, i_clk, i_rst_n, smp_acc, !i_in_ready)

    // Coefficient, clear and unused words make no result.
    `FQS_ASSERT_NEXT(a_no_result, i_clk, i_rst_n, other_acc && !i_out_valid, !i_out_valid)

    // A new result appears only at the end of a busy stretch.
    `FQS_ASSERT_NOW(a_result_after_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind fir_filter_q15_saturating_core fqs_checker u_fqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_smp.valid),
    .i_in_ready     (i_smp.ready),
    .i_in_action    (i_smp.action),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_filtered (o_res.filtered)
);
`default_nettype wire

// File: dv/fir_filter_q15_saturating_core_tb.sv
// Self-checking testbench of the Q15 FIR core: directed and random words against a tap model.
`timescale 1ns / 1ps
module fir_filter_q15_saturating_core_tb;
    import fqs_pkg::*;

    localparam int TAPS = DEF_TAPS;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 830;

    // Tap model: history, coefficients and write pointer, plus the filtered words still owed.
    class fir_q15_tracker;
        logic signed [SAMPLE_W-1:0] history [TAPS];
        logic signed [COEF_W-1:0]   coefs [TAPS];
        int unsigned                wr_ptr;
        logic signed [OUT_W-1:0]    owed_filtered [$];
        int unsigned                mismatches;

        function new();
            foreach (history[i]) history[i] = '0;
            foreach (coefs[i]) coefs[i] = '0;
            wr_ptr = 0;
            mismatches = 0;
        endfunction

        function void note_word(logic [ACTION_W-1:0] act, logic signed [SAMPLE_W-1:0] smp,
                                logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
            longint acc;
            longint shifted;
            int unsigned pos;
            case (act)
                ACT_COEF: begin
                    if (idx < TAPS) coefs[idx] = val;
                end
                ACT_CLEAR: begin
                    foreach (history[i]) history[i] = '0;
                    wr_ptr = 0;
                end
                ACT_SAMPLE: begin
                    history[wr_ptr] = smp;
                    pos = wr_ptr;
                    acc = 16384;
                    for (int k = 0; k < TAPS; k++) begin
                        acc += longint'(coefs[k]) * longint'(history[pos]);
                        // saturate after every add, not once at the end
                        if (acc > 64'sh3fffffff) acc = 64'sh3fffffff;
                        else if (acc < -64'sh40000000) acc = -64'sh40000000;
                        pos = (pos == 0) ? TAPS - 1 : pos - 1;
                    end
                    wr_ptr = (wr_ptr + 1) % TAPS;
                    shifted = acc >>> SHIFT;
                    owed_filtered.push_back(shifted[OUT_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_filtered(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (owed_filtered.size() == 0) begin
                $error("filtered: unexpected word, actual %0d", got);
                mismatches++;
            end else begin
                want = owed_filtered.pop_front();
                if (got !== want) begin
                    $error("filtered mismatch: expected %0d, actual %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return owed_filtered.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fqs_in_if  smp_if ();
    fqs_out_if res_if ();

    fir_filter_q15_saturating_core #(
        .TAPS (TAPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    fir_q15_tracker fir_model = new();

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    bit          hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Sample both channels with pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready)
                fir_model.note_word(smp_if.action, smp_if.sample, smp_if.coef_index,
                                    smp_if.coef_value);
            if (res_if.valid && res_if.ready)
                fir_model.check_filtered(res_if.filtered);
        end
    end

    // Receiver: random stalls, or a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Enter and leave at a falling edge; hold the word until accepted.
    task automatic send_word(logic [ACTION_W-1:0] act, logic signed [SAMPLE_W-1:0] smp,
                             logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.action     <= act;
        smp_if.sample     <= smp;
        smp_if.coef_index <= idx;
        smp_if.coef_value <= val;
        do @(posedge i_clk); while (!(smp_if.valid && smp_if.ready));
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_q15();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: return 16'($urandom_range(511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // Returns 1 when the word is one the block acts on.
    task automatic send_random_word(output bit counted);
        int unsigned pick;
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 80) begin
            send_word(ACT_SAMPLE, pick_q15(), 5'($urandom), 16'($urandom));
        end else if (pick < 93) begin
            send_word(ACT_COEF, 16'($urandom), 5'($urandom), pick_q15());
        end else if (pick < 97) begin
            send_word(ACT_CLEAR, 16'($urandom), 5'($urandom), 16'($urandom));
        end else begin
            send_word(ACT_UNUSED, 16'($urandom), 5'($urandom), 16'($urandom));
            counted = 1'b0;
        end
    endtask

    initial begin
        int unsigned idle_by_phase [4];
        int unsigned stall_by_phase [4];
        int unsigned sent;
        bit          counted;

        idle_by_phase  = '{0, 58, 0, 31};
        stall_by_phase = '{0, 0, 58, 31};
        smp_if.valid      = 1'b0;
        smp_if.action     = ACT_SAMPLE;
        smp_if.sample     = '0;
        smp_if.coef_index = '0;
        smp_if.coef_value = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero coefficients after reset give zero output.
        send_word(ACT_SAMPLE, 16'sh7fff, '0, '0);
        // Unused action must not touch the coefficients.
        send_word(ACT_UNUSED, 16'sh7fff, 5'd0, 16'sh7fff);
        send_word(ACT_SAMPLE, 16'sh7fff, '0, '0);
        send_word(ACT_COEF, '0, 5'd0, 16'sh7fff);
        send_word(ACT_COEF, '0, 5'd31, 16'sh8000);
        send_word(ACT_SAMPLE, 16'sh8000, '0, '0);
        send_word(ACT_SAMPLE, 16'sh0000, '0, '0);
        send_word(ACT_COEF, '0, 5'd1, 16'sh7fff);
        send_word(ACT_COEF, '0, 5'd2, 16'sh7fff);
        send_word(ACT_COEF, '0, 5'd3, 16'sh7fff);
        // Drive the accumulator into both rails.
        repeat (4) send_word(ACT_SAMPLE, 16'sh7fff, '0, '0);
        repeat (4) send_word(ACT_SAMPLE, 16'sh8000, '0, '0);
        // Clear keeps coefficients; history restarts from zero.
        send_word(ACT_CLEAR, 16'sh7fff, 5'd31, 16'sh7fff);
        send_word(ACT_SAMPLE, 16'sh0001, '0, '0);
        send_word(ACT_SAMPLE, 16'shffff, '0, '0);
        send_word(ACT_COEF, '0, 5'd0, 16'sh0000);
        send_word(ACT_SAMPLE, 16'sh4000, '0, '0);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = idle_by_phase[p];
            snk_stall_pct = stall_by_phase[p];
            if (p == 0) hold_req = 1'b1;
            sent = 0;
            while (sent < RANDOM_WORDS / 4) begin
                send_random_word(counted);
                if (counted) sent++;
            end
        end

        smp_if.valid <= 1'b0;
        snk_stall_pct = 0;
        while (fir_model.pending() != 0) @(posedge i_clk);
        repeat (TAPS + 16) @(posedge i_clk);

        if (fir_model.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_in_if.sv
hw/rtl/fqs_out_if.sv
hw/rtl/fir_filter_q15_saturating_core.sv
hw/rtl/fqs_checker.sv
dv/fir_filter_q15_saturating_core_tb.sv
